### hw/rtl/psv_pkg.sv
package psv_pkg;

  // Field and register widths.
  localparam int unsigned SampleBits  = 16;
  localparam int unsigned IndexBits   = 11;
  localparam int unsigned FreqBits    = 17;
  localparam int unsigned LenBits     = 12;
  localparam int unsigned MaxBits     = 20;
  localparam int unsigned CountBits   = 21;
  localparam int unsigned CoefBits    = 16;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 20;
  localparam int unsigned InDataBits  = 32;

  // Register reset values.
  localparam logic [FreqBits-1:0] PitchReset = 17'd7040;
  localparam logic [LenBits-1:0]  LenReset   = 12'd100;
  localparam logic [MaxBits-1:0]  MaxReset   = 20'd176400;

  // Damping coefficient: alpha = floor((f * 1024 + 625) / 1250) in Q0.16, where the
  // numerator is the frequency with 625 appended in the low ten bits. The quotient
  // is taken by an exact reciprocal multiply over the whole numerator range.
  localparam int unsigned AlphaFracBits  = 10;
  localparam int unsigned AlphaNumBits   = FreqBits + AlphaFracBits;
  localparam int unsigned AlphaRecipBits = 28;
  localparam int unsigned AlphaProdBits  = AlphaNumBits + AlphaRecipBits;
  localparam int unsigned AlphaShift     = 38;
  localparam int unsigned AlphaRawBits   = 17;
  localparam logic [AlphaFracBits-1:0]  AlphaBias  = 10'd625;
  localparam logic [AlphaRecipBits-1:0] AlphaRecip = 28'd219902326;
  localparam logic [CoefBits-1:0]       AlphaMin   = 16'd52429;
  localparam logic [CoefBits-1:0]       AlphaMax   = 16'd65503;
  localparam logic [CoefBits-1:0]       Gain       = 16'd64717;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_PITCH       = 2'd0,
    REG_LENGTH      = 2'd1,
    REG_MAX_SAMPLES = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COEF,
    ST_MUL_PREV,
    ST_MUL_CUR,
    ST_WRITE
  } psv_state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic coef;
    logic mul_prev;
    logic mul_cur;
    logic finish;
  } psv_cmd_t;

  typedef struct packed {
    logic out_busy;
  } psv_status_t;

endpackage

### hw/rtl/psv_ctrl.sv
module psv_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  psv_pkg::req_e         in_kind_i,
  output logic                  in_ready_o,
  input  psv_pkg::psv_status_t  status_i,
  output psv_pkg::psv_cmd_t     cmd_o
);
  import psv_pkg::*;

  psv_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == REQ_TICK) begin
            cmd_o.start = 1'b1;
            state_d     = ST_COEF;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_COEF: begin
        cmd_o.coef = 1'b1;
        state_d    = ST_MUL_PREV;
      end
      ST_MUL_PREV: begin
        cmd_o.mul_prev = 1'b1;
        state_d        = ST_MUL_CUR;
      end
      ST_MUL_CUR: begin
        cmd_o.mul_cur = 1'b1;
        state_d       = ST_WRITE;
      end
      ST_WRITE: begin
        // Hold the finished sample until the output register can take it.
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/psv_dp.sv
module psv_dp #(
  parameter int unsigned MAX_DELAY = 2048
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  psv_pkg::psv_cmd_t                    cmd_i,
  output psv_pkg::psv_status_t                 status_o,
  input  logic [psv_pkg::InDataBits-1:0]       in_data_i,
  input  logic [psv_pkg::FreqBits-1:0]         pitch_i,
  input  logic [psv_pkg::LenBits-1:0]          length_i,
  input  logic [psv_pkg::MaxBits-1:0]          max_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [psv_pkg::SampleBits-1:0] out_sample_o,
  output logic                                 out_done_o
);
  import psv_pkg::*;

  localparam int unsigned AW       = $clog2(MAX_DELAY);
  localparam int unsigned LW       = (AW + 1 > LenBits) ? AW + 1 : LenBits;
  localparam int unsigned ProdBits = CoefBits + 1 + SampleBits;
  localparam int unsigned AccBits  = ProdBits + 1;

  // Input fields.
  logic [IndexBits-1:0]         entry_index;
  logic signed [SampleBits-1:0] entry_value;
  assign entry_index = in_data_i[IndexBits-1:0];
  assign entry_value = in_data_i[IndexBits +: SampleBits];

  // Effective length, clamped to the store.
  logic [LW-1:0] len_raw, len_eff;
  assign len_raw = LW'(length_i);
  always_comb begin
    if (len_raw < LW'(2)) begin
      len_eff = LW'(2);
    end else if (len_raw > LW'(MAX_DELAY)) begin
      len_eff = LW'(MAX_DELAY);
    end else begin
      len_eff = len_raw;
    end
  end

  // Positions, note state.
  logic [AW-1:0]                rp_q, wp_q;
  logic [AW-1:0]                rp_fix, wp_fix, rp_next, wp_next;
  logic [LW-1:0]                rp_inc, wp_inc;
  logic signed [SampleBits-1:0] prev_q;
  logic [CountBits-1:0]         cnt_q;
  logic signed [SampleBits-1:0] rd_q;

  assign rp_fix  = (LW'(rp_q) >= len_eff) ? '0 : rp_q;
  assign wp_fix  = (LW'(wp_q) >= len_eff) ? '0 : wp_q;
  assign rp_inc  = LW'(rp_q) + LW'(1);
  assign wp_inc  = LW'(wp_q) + LW'(1);
  assign rp_next = (rp_inc >= len_eff) ? '0 : rp_inc[AW-1:0];
  assign wp_next = (wp_inc >= len_eff) ? '0 : wp_inc[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q   <= AW'(1);
      wp_q   <= '0;
      prev_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.load) begin
      rp_q   <= AW'(1);
      wp_q   <= '0;
      prev_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      rp_q <= rp_fix;
      wp_q <= wp_fix;
      if (cnt_q != '1) begin
        cnt_q <= cnt_q + CountBits'(1);
      end
    end else if (cmd_i.finish) begin
      rp_q   <= rp_next;
      wp_q   <= wp_next;
      prev_q <= rd_q;
    end
  end

  // Delay line memory: one write and one registered read port.
  logic signed [SampleBits-1:0] mem [MAX_DELAY];
  logic [LW-1:0]                idx_wide;
  logic                         idx_ok;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic signed [SampleBits-1:0] mem_wdata;
  logic signed [SampleBits-1:0] nxt;

  assign idx_wide  = LW'(entry_index);
  assign idx_ok    = idx_wide < LW'(MAX_DELAY);
  assign mem_we    = (cmd_i.load & idx_ok) | cmd_i.finish;
  assign mem_waddr = cmd_i.load ? idx_wide[AW-1:0] : wp_q;
  assign mem_wdata = cmd_i.load ? entry_value : nxt;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.start) begin
      rd_q <= mem[rp_fix];
    end
  end

  // Coefficients.
  logic [AlphaProdBits-1:0] alpha_prod_q;
  logic [AlphaRawBits-1:0]  alpha_raw;
  logic [CoefBits-1:0]      alpha;
  logic [2*CoefBits-1:0]    ag_q;
  logic [CoefBits-1:0]      ag_hi, k0, k1;

  assign alpha_raw = alpha_prod_q[AlphaShift +: AlphaRawBits];
  always_comb begin
    if (alpha_raw < AlphaRawBits'(AlphaMin)) begin
      alpha = AlphaMin;
    end else if (alpha_raw > AlphaRawBits'(AlphaMax)) begin
      alpha = AlphaMax;
    end else begin
      alpha = alpha_raw[CoefBits-1:0];
    end
  end

  // k1 rounds alpha*G to nearest; k0 is the matching rounding of (1-alpha)*G.
  assign ag_hi = ag_q[2*CoefBits-1:CoefBits];
  assign k1    = ag_hi + CoefBits'(ag_q[CoefBits-1]);
  assign k0    = Gain - ag_hi
               - CoefBits'(ag_q[CoefBits-1:0] > {1'b1, {(CoefBits-1){1'b0}}});

  logic signed [CoefBits:0]    k0_s, k1_s;
  logic signed [ProdBits-1:0]  prod_q;
  logic signed [AccBits-1:0]   acc_q, acc_rnd, acc_sh;
  logic [AccBits-SampleBits:0] acc_hi;

  assign k0_s = signed'({1'b0, k0});
  assign k1_s = signed'({1'b0, k1});

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      alpha_prod_q <= AlphaProdBits'({pitch_i, AlphaBias}) * AlphaProdBits'(AlphaRecip);
    end
    if (cmd_i.coef) begin
      ag_q <= (2*CoefBits)'(alpha) * (2*CoefBits)'(Gain);
    end
    if (cmd_i.mul_prev) begin
      prod_q <= ProdBits'(k0_s * prev_q);
    end
    if (cmd_i.mul_cur) begin
      acc_q <= AccBits'(prod_q) + AccBits'(k1_s * rd_q);
    end
  end

  // Round to nearest with ties upward, then saturate to the sample range.
  assign acc_rnd = acc_q + (AccBits'(1) << (CoefBits - 1));
  assign acc_sh  = acc_rnd >>> CoefBits;
  assign acc_hi  = acc_sh[AccBits-1:SampleBits-1];
  always_comb begin
    if ((acc_hi == '0) || (acc_hi == '1)) begin
      nxt = acc_sh[SampleBits-1:0];
    end else if (acc_sh[AccBits-1]) begin
      nxt = {1'b1, {(SampleBits-1){1'b0}}};
    end else begin
      nxt = {1'b0, {(SampleBits-1){1'b1}}};
    end
  end

  // Output register.
  logic                         out_valid_q;
  logic signed [SampleBits-1:0] out_sample_q;
  logic                         out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_sample_q <= rd_q;
      out_done_q   <= cnt_q > CountBits'(max_i);
    end
  end

  assign status_o.out_busy = out_valid_q & ~out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_sample_o      = out_sample_q;
  assign out_done_o        = out_done_q;

endmodule

### hw/rtl/plucked_string_voice_core.sv
// Plucked string voice core.
// Items arrive as beats on the s_axis stream. tuser selects the kind: a load beat
// writes one delay line entry and restarts the note, a tick beat produces one
// sample. Every entry below the delay length must be loaded before ticks start.
// Each tick yields one beat on m_axis: the sample in tdata and note_done in tuser.
// Configuration goes through the cfg write channel (index 0 pitch, 1 delay length,
// 2 max samples) and is always ready; write it only while the voice is idle.
// A load beat is taken while the voice is idle and leaves it idle. A tick beat
// walks through the coefficient multiply, the two product steps and the delay
// memory write-back, and its result enters the output register with that
// write-back; no new beat is accepted until the voice is back in idle.
// Reset puts the note state back (read position 1, write position 0, previous
// output and sample count zero) and restores the register defaults; the delay
// memory keeps no reset and holds garbage until loaded.
// When the receiver stalls, the result waits in the output register while the
// next beat is still accepted; a tick then waits in its write-back step until the
// pending result has been taken.
module plucked_string_voice_core #(
  parameter int unsigned MAX_DELAY = 2048
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input stream.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [psv_pkg::InDataBits-1:0]        s_axis_tdata,  // entry_index, entry_value
  input  logic                                  s_axis_tuser,  // req_type
  // Output stream.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [psv_pkg::SampleBits-1:0]        m_axis_tdata,  // sample
  output logic                                  m_axis_tuser,  // note_done
  // Configuration write channel.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [psv_pkg::CfgIdxBits-1:0]        cfg_index_i,
  input  logic [psv_pkg::CfgDataBits-1:0]       cfg_data_i
);
  import psv_pkg::*;

  // Configuration registers. Writes to unused indexes are dropped.
  logic [FreqBits-1:0] pitch_q;
  logic [LenBits-1:0]  length_q;
  logic [MaxBits-1:0]  max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q  <= PitchReset;
      length_q <= LenReset;
      max_q    <= MaxReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PITCH:       pitch_q  <= cfg_data_i[FreqBits-1:0];
        REG_LENGTH:      length_q <= cfg_data_i[LenBits-1:0];
        REG_MAX_SAMPLES: max_q    <= cfg_data_i[MaxBits-1:0];
        default: ;
      endcase
    end
  end

  psv_cmd_t    cmd;
  psv_status_t status;
  logic signed [SampleBits-1:0] out_sample;

  psv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (req_e'(s_axis_tuser)),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  psv_dp #(
    .MAX_DELAY (MAX_DELAY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_data_i    (s_axis_tdata),
    .pitch_i      (pitch_q),
    .length_i     (length_q),
    .max_i        (max_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (out_sample),
    .out_done_o   (m_axis_tuser)
  );

  assign m_axis_tdata = out_sample;

endmodule

### hw/rtl/psv_checker.sv
module psv_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [psv_pkg::SampleBits-1:0]     m_axis_tdata,
  input logic                               m_axis_tuser
);
  import psv_pkg::*;

  logic tick_beat, load_beat;
  assign tick_beat = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_TICK);
  assign load_beat = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_LOAD);

  // A result held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // A tick occupies the voice, so the next cycle takes no new beat.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_beat |=> !s_axis_tready)
    else $error("input ready right after a tick");

  // After a load the voice is ready again in the next cycle.
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_beat |=> s_axis_tready)
    else $error("input not ready after a load");

  // A fresh result must come from a tick accepted earlier, through the coefficient, product and write-back states.
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(tick_beat, 5))
    else $error("output beat without a matching tick");

endmodule

bind plucked_string_voice_core psv_checker u_psv_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps

// Testbench for the plucked string voice core.
//
// The scoreboard class keeps its own copy of the delay line, the note state and
// the three registers. Every input beat that the core accepts goes into it.
// A tick beat pushes the sample and note_done flag that the core must return.
// Every output beat is checked against the oldest pending expectation.
//
// The delay memory in the core has no reset. The run therefore starts by
// loading the low part of it once, and the scoreboard remembers which entries
// have been written. A tick that would read an entry never written is sent as
// a load of that entry instead.
//
// A short directed part comes next. It covers:
//   - both damping clamps;
//   - line lengths below the minimum and above the memory size;
//   - shrinking the line in the middle of a note;
//   - note_done from the very first sample.
//
// Random notes follow:
//   - most are a configuration, a load of the line and a burst of ticks;
//   - a few are malformed load patterns with stray restarts.
//
// Both stream sides idle at random. Twice the receiver holds off for a long
// stretch while ticks keep coming, so the core fills up and stalls its input.
module tb;
  import psv_pkg::*;

  localparam int unsigned LineDepth   = 2048;
  localparam int unsigned FillDepth   = 64;
  localparam int unsigned CountTop    = (1 << CountBits) - 1;
  localparam int unsigned IdlePad     = 8;
  localparam int unsigned EndPad      = 20;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned LoadBurst   = 24;

  typedef struct {
    logic [SampleBits-1:0] sample;
    logic                  note_done;
  } voice_result_t;

  // Tracks the voice state and holds the samples that the core still owes.
  class voice_scoreboard;
    logic signed [SampleBits-1:0] line_mem [LineDepth];
    bit                           written [LineDepth];
    int unsigned                  rd_pos;
    int unsigned                  wr_pos;
    int unsigned                  sample_count;
    logic signed [SampleBits-1:0] prev_out;
    logic [FreqBits-1:0]          pitch;
    logic [LenBits-1:0]           line_len;
    logic [MaxBits-1:0]           max_samples;
    voice_result_t                expected_samples[$];
    int unsigned                  errors;
    int unsigned                  checked;
    int unsigned                  done_seen;

    function new();
      pitch       = PitchReset;
      line_len    = LenReset;
      max_samples = MaxReset;
      restart_note();
    endfunction

    function void restart_note();
      wr_pos       = 0;
      rd_pos       = 1;
      prev_out     = '0;
      sample_count = 0;
    endfunction

    function void set_reg(cfg_reg_e sel, logic [CfgDataBits-1:0] data);
      case (sel)
        REG_PITCH:       pitch       = data[FreqBits-1:0];
        REG_LENGTH:      line_len    = data[LenBits-1:0];
        REG_MAX_SAMPLES: max_samples = data[MaxBits-1:0];
        default: ;
      endcase
    endfunction

    // The programmed length is clamped to the range that the memory can hold.
    function int unsigned line_length();
      if (line_len < 2) return 2;
      if (line_len > LineDepth) return LineDepth;
      return 32'(line_len);
    endfunction

    // Entry that the next tick reads, once a shortened line is accounted for.
    function int unsigned next_read_pos();
      return (rd_pos >= line_length()) ? 0 : rd_pos;
    endfunction

    function void note_item(req_e kind, logic [IndexBits-1:0] idx,
                            logic signed [SampleBits-1:0] value);
      int unsigned                  len;
      longint                       alpha;
      longint                       k0;
      longint                       k1;
      longint                       acc;
      longint                       nxt;
      logic signed [SampleBits-1:0] cur;
      voice_result_t                res;
      if (kind == REQ_LOAD) begin
        line_mem[idx] = value;
        written[idx]  = 1'b1;
        restart_note();
        return;
      end
      len = line_length();
      // A position left outside a shortened line starts over at zero.
      if (rd_pos >= len) rd_pos = 0;
      if (wr_pos >= len) wr_pos = 0;
      // Damping coefficient in Q0.16, rounded, then clamped to [0.8, 0.9995].
      alpha = (longint'(pitch) * 65536 + 40000) / 80000;
      if (alpha < longint'(AlphaMin)) alpha = longint'(AlphaMin);
      if (alpha > longint'(AlphaMax)) alpha = longint'(AlphaMax);
      k1 = (alpha * longint'(Gain) + 32768) >>> 16;
      k0 = ((65536 - alpha) * longint'(Gain) + 32768) >>> 16;
      if (sample_count < CountTop) sample_count++;
      cur = line_mem[rd_pos];
      acc = k0 * longint'(prev_out) + k1 * longint'(cur);
      // Round to nearest with ties upward, then saturate to the sample range.
      nxt = (acc + 32768) >>> 16;
      if (nxt > 32767) nxt = 32767;
      if (nxt < -32768) nxt = -32768;
      prev_out         = cur;
      line_mem[wr_pos] = nxt[SampleBits-1:0];
      written[wr_pos]  = 1'b1;
      rd_pos = (rd_pos + 1 >= len) ? 0 : rd_pos + 1;
      wr_pos = (wr_pos + 1 >= len) ? 0 : wr_pos + 1;
      res.sample    = cur;
      res.note_done = (sample_count > max_samples);
      expected_samples.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      errors++;
    endtask

    task check_sample(logic [SampleBits-1:0] sample, logic note_done);
      voice_result_t want;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample %h arrived with none pending", sample));
        return;
      end
      want = expected_samples.pop_front();
      checked++;
      if (note_done === 1'b1) done_seen++;
      if (sample !== want.sample)
        report_mismatch($sformatf("sample %0d: got %h, want %h",
                                  checked, sample, want.sample));
      if (note_done !== want.note_done)
        report_mismatch($sformatf("sample %0d: note_done got %b, want %b",
                                  checked, note_done, want.note_done));
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata;  // entry_index, entry_value
  logic                   s_axis_tuser;  // req_type
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [SampleBits-1:0]  m_axis_tdata;  // sample
  logic                   m_axis_tuser;  // note_done
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  voice_scoreboard voice = new();

  // Stimulus knobs and run counters; hold_request and holds_done are shared with the receiver process.
  bit          sender_calm;
  bit          hold_request;
  int unsigned quiet_cycles;
  int unsigned loads_sent;
  int unsigned ticks_sent;
  int unsigned holds_done;

  plucked_string_voice_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Idle gaps: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one beat and returns at the edge where the core takes it.
  // The valid is left high on purpose. The next call either keeps it high
  // or drops it for a gap, so at most one assignment lands per edge.
  task automatic send_item(req_e kind, logic [IndexBits-1:0] idx,
                           logic [SampleBits-1:0] value);
    int unsigned gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(InDataBits - IndexBits - SampleBits){1'b0}}, value, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    voice.note_item(kind, idx, value);
    if (kind == REQ_LOAD) loads_sent++;
    else ticks_sent++;
  endtask

  // Index and value of a tick are ignored by the core, so they carry noise.
  // If the entry that the tick would read was never written, it is loaded
  // instead; the restart then points the read at an entry of the first fill.
  task automatic send_tick();
    int unsigned pos;
    pos = voice.next_read_pos();
    if (!voice.written[pos]) begin
      send_item(REQ_LOAD, IndexBits'(pos), SampleBits'($urandom));
    end else begin
      send_item(REQ_TICK, IndexBits'($urandom), SampleBits'($urandom));
    end
  endtask

  // Waits until every owed sample has come back. The extra pad covers a load
  // that is still being written, since a load gives no beat to wait for.
  task automatic drain_voice();
    s_axis_tvalid <= 1'b0;
    while (voice.expected_samples.size() != 0) @(posedge clk_i);
    repeat (IdlePad) @(posedge clk_i);
  endtask

  task automatic write_one(cfg_reg_e sel, logic [CfgDataBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    voice.set_reg(sel, data);
  endtask

  // Registers change only while the voice is idle.
  task automatic write_regs(logic [CfgDataBits-1:0] pitch_data,
                            logic [CfgDataBits-1:0] len_data,
                            logic [CfgDataBits-1:0] max_data);
    drain_voice();
    write_one(REG_PITCH, pitch_data);
    write_one(REG_LENGTH, len_data);
    write_one(REG_MAX_SAMPLES, max_data);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver. Takes beats with random stalls, in epochs that are either calm
  // or busy. On request it holds off for a long stretch that it counts itself.
  initial begin
    int unsigned stall;
    int unsigned epoch;
    int unsigned held;
    bit          calm;
    stall = 0;
    epoch = 0;
    calm  = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        for (held = 1; held < HoldCycles; held++) @(posedge clk_i);
        hold_request = 1'b0;
        holds_done++;
      end else begin
        epoch++;
        if (epoch % 128 == 0) calm = ($urandom_range(0, 3) == 0);
        if (stall == 0 && !calm && $urandom_range(0, 3) == 0) stall = pick_gap();
        m_axis_tready <= (stall == 0);
        if (stall != 0) stall--;
      end
    end
  end

  // Output checking. Sampled at the edge, so the values seen are the
  // ones the handshake was decided on.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      voice.check_sample(m_axis_tdata, m_axis_tuser);
  end

  // Watchdog. Ends the run once nothing at all has been accepted for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Timeout: no beat accepted for %0d cycles", QuietLimit);
      $display("plucked_string_voice_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned random_items;
    int unsigned notes;
    int unsigned eff_len;
    int unsigned n_loads;
    int unsigned n_ticks;
    int unsigned i;
    logic [CfgDataBits-1:0] pitch_data;
    logic [CfgDataBits-1:0] len_data;
    logic [CfgDataBits-1:0] max_data;
    random_items = 0;
    notes        = 0;
    sender_calm  = 1'b0;
    hold_request = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_PITCH;
    cfg_data_i    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the low part of the delay memory once. Short notes read only here.
    for (i = 0; i < FillDepth; i++)
      send_item(REQ_LOAD, IndexBits'(i), SampleBits'($urandom));

    // Reset register values: a couple of ticks on the default line.
    send_tick();
    send_tick();

    // Shortest line and the lowest damping clamp. note_done is set from the
    // first sample because the limit is zero. Both sample extremes are loaded.
    write_regs(20'd0, 20'd0, 20'd0);
    send_item(REQ_LOAD, 11'd0, 16'h7fff);
    send_item(REQ_LOAD, 11'd1, 16'h8000);
    repeat (4) send_tick();

    // Highest damping clamp, a length of one (acts as two), a load at the top
    // index, and note_done rising partway through the note.
    write_regs(20'h1ffff, 20'd1, 20'd3);
    send_item(REQ_LOAD, 11'h7ff, 16'h8000);
    send_item(REQ_LOAD, 11'd0, 16'h0001);
    send_item(REQ_LOAD, 11'd1, 16'hffff);
    repeat (5) send_tick();

    // A length beyond the memory acts as the full memory. The line is then
    // shrunk mid-note, which leaves both positions outside it.
    write_regs(20'd80000, 20'hfff, 20'hfffff);
    repeat (6) send_tick();
    write_regs(20'd7040, 20'd3, 20'hfffff);
    repeat (3) send_tick();

    // Random notes. Most configure the voice, load the line in order and then
    // tick. A few scatter loads anywhere, and stray loads restart notes.
    while (random_items < RandomItems) begin
      notes++;
      sender_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0:       pitch_data = CfgDataBits'($urandom);
        1:       pitch_data = CfgDataBits'($urandom_range(0, 131071));
        default: pitch_data = CfgDataBits'($urandom_range(63000, 81000));
      endcase
      case ($urandom_range(0, 19))
        0:       len_data = CfgDataBits'($urandom_range(0, 1));
        1:       len_data = CfgDataBits'($urandom_range(2049, 4095));
        2:       len_data = CfgDataBits'($urandom_range(25, 2048));
        default: len_data = CfgDataBits'($urandom_range(2, 24));
      endcase
      if ($urandom_range(0, 4) == 0) max_data = CfgDataBits'($urandom);
      else max_data = CfgDataBits'($urandom_range(0, 40));
      write_regs(pitch_data, len_data, max_data);
      eff_len = voice.line_length();

      if ($urandom_range(0, 9) != 0) begin
        n_loads = (eff_len <= LoadBurst) ? eff_len : LoadBurst;
        for (i = 0; i < n_loads; i++)
          send_item(REQ_LOAD,
                    IndexBits'((eff_len <= LoadBurst) ? i : $urandom_range(0, eff_len - 1)),
                    SampleBits'($urandom));
      end else begin
        n_loads = $urandom_range(0, 6);
        for (i = 0; i < n_loads; i++)
          send_item(REQ_LOAD, IndexBits'($urandom), SampleBits'($urandom));
      end

      // Two notes flood the core with ticks while the receiver holds off.
      n_ticks = $urandom_range(1, 40);
      if (notes == 3 || notes == 9) begin
        n_ticks      = 40;
        sender_calm  = 1'b1;
        hold_request = 1'b1;
      end
      for (i = 0; i < n_ticks; i++) begin
        if ($urandom_range(0, 29) == 0) begin
          send_item(REQ_LOAD, IndexBits'($urandom_range(0, eff_len - 1)),
                    SampleBits'($urandom));
        end else begin
          send_tick();
        end
      end
      random_items += n_loads + n_ticks;
    end

    drain_voice();
    repeat (EndPad) @(posedge clk_i);
    if (voice.expected_samples.size() != 0)
      voice.report_mismatch($sformatf("%0d samples never arrived",
                                      voice.expected_samples.size()));

    $display("Run covered %0d loads and %0d ticks over %0d random notes plus the directed part.",
             loads_sent, ticks_sent, notes);
    $display("Checked %0d samples, %0d of them with note_done, %0d long receiver holds.",
             voice.checked, voice.done_seen, holds_done);
    if (voice.errors == 0) begin
      $display("plucked_string_voice_core verification clean");
    end else begin
      $display("plucked_string_voice_core verification failed");
    end
    $finish;
  end

endmodule

### plucked_string_voice_core.f
hw/rtl/psv_pkg.sv
hw/rtl/psv_ctrl.sv
hw/rtl/psv_dp.sv
hw/rtl/plucked_string_voice_core.sv
hw/rtl/psv_checker.sv
tb/tb.sv
